@@ rtl/core/vtd_pkg.sv @@
// Shared types and constants for the varint TLV message deframer.
package vtd_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam logic [27:0] LEN_MAX = 28'hFFFFFFF;
    localparam logic [7:0] TYPE_COMMAND = 8'h05;
    localparam logic [7:0] TYPE_CONFIG  = 8'h09;
    localparam logic [7:0] TYPE_UPDATE  = 8'h0a;

    typedef enum logic [3:0] {
        PH_HDR  = 4'd0,
        PH_HLEN = 4'd1,
        PH_TYPE = 4'd2,
        PH_MLEN = 4'd3,
        PH_KLEN = 4'd4,
        PH_KEY  = 4'd5,
        PH_VAL  = 4'd6,
        PH_UPD  = 4'd7,
        PH_SKIP = 4'd8,
        PH_DROP = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_VALUE = 2'd2,
        KIND_VER   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        kind_t       item_kind;
        logic        is_command;
        logic [7:0]  out_byte;
        logic [31:0] app_version;
        logic        last_in_message;
        status_t     status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/core/vtd_parser.sv @@
// Front part: byte parser that classifies each request and builds its result.
module vtd_parser #(
    parameter int MAX_LENGTH_BYTES = vtd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             res_valid,
    input  logic             res_ready,
    output vtd_pkg::result_t res
);
    import vtd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [27:0] acc_reg, acc_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [27:0] body_reg, body_next;
    logic [27:0] key_reg, key_next;
    logic [31:0] ver_reg, ver_next;

    logic        dig_bad, dig_more;
    logic [27:0] dig_acc;
    logic [27:0] dig_val;
    logic [34:0] dig_sum;
    logic [27:0] body_dec;
    logic        go;
    result_t     r;
    logic        emit;

    assign in_ready = res_ready;
    assign go = in_valid && in_ready;
    assign body_dec = body_reg - 28'd1;

    always_comb
    begin
        dig_bad = ({29'd0, dcnt_reg} >= 32'(MAX_LENGTH_BYTES));
        dig_more = data_byte[7];
        dig_sum = '0;
        dig_acc = acc_reg;
        if (dcnt_reg >= 3'd4)
        begin
            if (data_byte[6:0] != 7'd0)
                dig_acc = LEN_MAX;
        end
        else
        begin
            dig_sum = {7'd0, acc_reg} + ({28'd0, data_byte[6:0]} << (7 * dcnt_reg));
            dig_acc = (dig_sum > {7'd0, LEN_MAX}) ? LEN_MAX : dig_sum[27:0];
        end
        dig_val = dig_acc;
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next = acc_reg;
        dcnt_next = dcnt_reg;
        mtype_next = mtype_reg;
        body_next = body_reg;
        key_next = key_reg;
        ver_next = ver_reg;
        r = '0;
        case (phase_reg)
            PH_HLEN, PH_MLEN, PH_KLEN:
            begin
                if (dig_bad)
                begin
                    phase_next = PH_DROP;
                    r.status = ST_MALFORMED;
                end
                else
                begin
                    acc_next = dig_acc;
                    dcnt_next = dcnt_reg + 3'd1;
                    if (!dig_more)
                    begin
                        acc_next = '0;
                        dcnt_next = '0;
                    end
                    if (phase_reg == PH_HLEN)
                    begin
                        if (!dig_more)
                            phase_next = PH_TYPE;
                    end
                    else if (phase_reg == PH_MLEN)
                    begin
                        if (!dig_more)
                        begin
                            body_next = dig_val;
                            key_next = '0;
                            ver_next = '0;
                            if (dig_val == 28'd0)
                                phase_next = PH_TYPE;
                            else if (mtype_reg == TYPE_CONFIG || mtype_reg == TYPE_COMMAND)
                                phase_next = PH_KLEN;
                            else if (mtype_reg == TYPE_UPDATE && dig_val >= 28'd5)
                                phase_next = PH_UPD;
                            else
                                phase_next = PH_SKIP;
                        end
                    end
                    else
                    begin
                        body_next = body_dec;
                        if (dig_more)
                        begin
                            if (body_dec == 28'd0)
                            begin
                                acc_next = '0;
                                dcnt_next = '0;
                                phase_next = PH_TYPE;
                            end
                        end
                        else if (dig_val > body_dec)
                            phase_next = (body_dec == 28'd0) ? PH_TYPE : PH_SKIP;
                        else if (body_dec == 28'd0)
                            phase_next = PH_TYPE;
                        else
                        begin
                            key_next = dig_val;
                            phase_next = (dig_val != 28'd0) ? PH_KEY : PH_VAL;
                        end
                    end
                end
            end
            PH_TYPE:
            begin
                mtype_next = data_byte;
                phase_next = PH_MLEN;
            end
            PH_KEY, PH_VAL:
            begin
                r.item_kind = (phase_reg == PH_KEY) ? KIND_KEY : KIND_VALUE;
                r.is_command = (mtype_reg == TYPE_COMMAND);
                r.out_byte = data_byte;
                body_next = body_dec;
                if (phase_reg == PH_KEY)
                    key_next = key_reg - 28'd1;
                if (body_dec == 28'd0)
                begin
                    r.last_in_message = 1'b1;
                    phase_next = PH_TYPE;
                end
                else if (phase_reg == PH_KEY && key_reg == 28'd1)
                    phase_next = PH_VAL;
            end
            PH_UPD:
            begin
                if (key_reg >= 28'd1 && key_reg <= 28'd4)
                    ver_next = {ver_reg[23:0], data_byte};
                if (key_reg == 28'd4)
                begin
                    r.item_kind = KIND_VER;
                    r.app_version = ver_next;
                end
                key_next = key_reg + 28'd1;
                body_next = body_dec;
                if (body_dec == 28'd0)
                    phase_next = PH_TYPE;
                else if (key_reg >= 28'd4)
                    phase_next = PH_SKIP;
            end
            PH_SKIP:
            begin
                body_next = body_dec;
                if (body_dec == 28'd0)
                    phase_next = PH_TYPE;
            end
            PH_DROP:
            begin
            end
            default:
            begin
                acc_next = '0;
                dcnt_next = '0;
                phase_next = PH_HLEN;
            end
        endcase
        if (last_byte)
        begin
            if (r.status != ST_MALFORMED && phase_next != PH_TYPE && phase_next != PH_DROP)
                r.status = ST_TRUNCATED;
            phase_next = PH_HDR;
            acc_next = '0;
            dcnt_next = '0;
            mtype_next = '0;
            body_next = '0;
            key_next = '0;
            ver_next = '0;
        end
        emit = (r.item_kind != KIND_NONE) || (r.status != ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            acc_reg <= '0;
            dcnt_reg <= '0;
            mtype_reg <= '0;
            body_reg <= '0;
            key_reg <= '0;
            ver_reg <= '0;
            res_valid <= 1'b0;
        end
        else
        begin
            if (res_ready)
                res_valid <= go && emit;
            if (go)
            begin
                phase_reg <= phase_next;
                acc_reg <= acc_next;
                dcnt_reg <= dcnt_next;
                mtype_reg <= mtype_next;
                body_reg <= body_next;
                key_reg <= key_next;
                ver_reg <= ver_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
            res <= r;
    end

endmodule

@@ rtl/core/vtd_queue.sv @@
// Back part: short result queue that decouples the parser from the output.
module vtd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  vtd_pkg::result_t in_res,
    output logic             out_valid,
    input  logic             out_ready,
    output vtd_pkg::result_t out_res
);
    import vtd_pkg::*;

    result_t    mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign in_ready = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_res = mem[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 2'd1;
            if (rd)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= in_res;
    end

endmodule

@@ rtl/core/varint_tlv_message_deframer.sv @@
// Top level of the varint TLV message deframer.
// One payload byte is taken per clock cycle while the queue has room; the parser decides
// each byte combinationally and hands its result through one register stage into a
// four-entry queue, so input is refused only when that queue is nearly full.
module varint_tlv_message_deframer #(
    parameter int MAX_LENGTH_BYTES = vtd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // item_kind, is_command, out_byte, app_version, status
    output logic        m_axis_tlast    // last_in_message
);
    import vtd_pkg::*;

    logic    p_valid, q_ready;
    result_t p_res, q_res;

    vtd_parser #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_parser (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .data_byte(s_axis_tdata), .last_byte(s_axis_tlast),
        .res_valid(p_valid), .res_ready(q_ready), .res(p_res)
    );

    vtd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(p_valid), .in_ready(q_ready), .in_res(p_res),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(q_res)
    );

    assign m_axis_tdata = {3'd0, q_res.status, q_res.app_version, q_res.out_byte,
                           q_res.is_command, q_res.item_kind};
    assign m_axis_tlast = q_res.last_in_message;

endmodule

@@ rtl/core/vtd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
module vtd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import vtd_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed.");
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != KIND_NONE || m_axis_tdata[44:43] != ST_OK))
        else $error("Empty result delivered.");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[44:43] != 2'd3)
        else $error("Bad status code.");
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[1:0] == KIND_KEY || m_axis_tdata[1:0] == KIND_VALUE))
        else $error("Message end on a non-body result.");
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tready))
        else $error("Input ready is unknown.");
endmodule

bind varint_tlv_message_deframer vtd_checker u_vtd_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
